@@ hw/rtl/plrm_pkg.sv @@
package plrm_pkg;

  localparam int PCT_FRAC_BITS_DEF  = 16;
  localparam int RATE_FRAC_BITS_DEF = 8;
  localparam int PCT_W              = 23;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] packet_id;
    logic signed [31:0] content;
  } plrm_in_t;

  typedef struct packed {
    logic signed [31:0] data_amount;
    logic [31:0]        lost_since_reset;
    logic [23:0]        recv_this_second;
    logic [31:0]        lost_this_second;
    logic [PCT_W-1:0]   loss_percent;
    logic [PCT_W-1:0]   mean_loss_percent;
    logic [PCT_W-1:0]   stdev_loss_percent;
    logic [31:0]        mean_recv_rate;
    logic [31:0]        sdev_recv_rate;
  } plrm_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PCT, ST_PSQ, ST_ACC, ST_ML, ST_EL, ST_MLSQ, ST_LSQRT,
    ST_MR, ST_ER, ST_MRSQ, ST_RSQRT, ST_OUT
  } plrm_state_t;

  typedef struct packed {
    logic        pkt_we;
    logic        start;
    logic        capture;
    logic        accum;
    logic        out_load;
    plrm_state_t step;
  } plrm_cmd_t;

endpackage

@@ hw/rtl/packet_loss_rate_monitor_unit.sv @@
// Packet beat: accepted, no result; next beat may follow at once.
// Tick beat: computes the loss percent and its square, accumulates, then mean, mean
// square, variance and root for loss and then for rate, on the shared bit-serial
// divider, multiplier and root, and then loads the result.
// No beat is taken while a tick is in work; a waiting result stalls only the tick.
// Reset (rst_n low, synchronous) clears all counters, sums and handshake state.
module packet_loss_rate_monitor_unit #(
  parameter int PCT_FRAC_BITS  = plrm_pkg::PCT_FRAC_BITS_DEF,
  parameter int RATE_FRAC_BITS = plrm_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plrm_pkg::plrm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output plrm_pkg::plrm_out_t out_data
);
  import plrm_pkg::*;

  plrm_cmd_t cmd;
  logic      busy;

  plrm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_mode(in_data.mode), .in_ready,
    .out_valid, .out_ready, .busy, .cmd
  );

  plrm_datapath #(
    .PCT_FRAC_BITS(PCT_FRAC_BITS), .RATE_FRAC_BITS(RATE_FRAC_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .in_data, .busy, .out_data
  );
endmodule

@@ hw/rtl/plrm_div.sv @@
module plrm_div #(
  parameter int DW = 96
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [63:0]   divisor,
  output logic          busy,
  output logic [63:0]   quot
);
  localparam int CW = $clog2(DW + 1);

  logic [63:0]   rem_r;
  logic [DW-1:0] quo_r;
  logic [63:0]   den_r;
  logic [CW-1:0] cnt_r;
  logic [64:0]   trial;
  logic          ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign busy  = cnt_r != '0;
  assign quot  = (|quo_r[DW-1:64]) ? '1 : quo_r[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
      cnt_r <= CW'(DW);
    end else if (busy) begin
      // restoring step: one quotient bit a cycle
      rem_r <= ge ? 64'(trial - {1'b0, den_r}) : trial[63:0];
      quo_r <= {quo_r[DW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end
endmodule

@@ hw/rtl/plrm_sqrt.sv @@
module plrm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [63:0] root
);
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign busy  = bit_r != '0;
  assign root  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (start) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end
endmodule

@@ hw/rtl/plrm_datapath.sv @@
module plrm_datapath #(
  parameter int PCT_FRAC_BITS  = plrm_pkg::PCT_FRAC_BITS_DEF,
  parameter int RATE_FRAC_BITS = plrm_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  plrm_pkg::plrm_cmd_t cmd,
  input  plrm_pkg::plrm_in_t  in_data,
  output logic                busy,
  output plrm_pkg::plrm_out_t out_data
);
  import plrm_pkg::*;

  localparam int MAXFB = (PCT_FRAC_BITS > 2 * RATE_FRAC_BITS) ?
                         PCT_FRAC_BITS : 2 * RATE_FRAC_BITS;
  localparam int DW = 64 + MAXFB;
  localparam logic [55:0] M56 = '1;

  function automatic logic [63:0] sadd64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [55:0] sadd56(logic [55:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {9'd0, a} + {1'b0, b};
    return (s > {9'd0, M56}) ? M56 : s[55:0];
  endfunction

  logic [31:0] prev_id_r, start_r, latest_r, lost_tot_r, sec_lost_r, tick_cnt_r;
  logic        first_r;
  logic [23:0] sec_recv_r;
  logic [55:0] lp_sum_r, r_sum_r;
  logic [63:0] lp_sq_r, r_sq_r;
  logic [63:0] pct_r, psq_r, ml_r, mr_r, ex_r, var_r, sdl_r, sdr_r;
  plrm_out_t   out_r;

  // shared units
  logic          div_start, mul_start, sqrt_start;
  logic          div_busy, mul_busy, sqrt_busy;
  logic [DW-1:0] dvd;
  logic [63:0]   dvs, div_q, mul_a, mul_b, mul_p, sqrt_q;
  logic [32:0]   den_pct;
  logic [38:0]   l100;

  assign den_pct = {9'd0, sec_recv_r} + {1'b0, sec_lost_r};
  assign l100    = 39'(sec_lost_r) * 39'd100;

  always_comb begin
    dvd = '0;
    dvs = {32'd0, tick_cnt_r};
    case (cmd.step)
      ST_PCT: begin
        dvd = DW'(l100) << PCT_FRAC_BITS;
        dvs = 64'(den_pct);
      end
      ST_ML:   dvd = DW'(lp_sum_r);
      ST_EL:   dvd = DW'(lp_sq_r);
      ST_MR:   dvd = DW'(r_sum_r) << RATE_FRAC_BITS;
      ST_ER:   dvd = DW'(r_sq_r) << (2 * RATE_FRAC_BITS);
      default: dvd = '0;
    endcase
  end

  always_comb begin
    case (cmd.step)
      ST_PSQ:  mul_a = pct_r;
      ST_MLSQ: mul_a = ml_r;
      default: mul_a = mr_r;
    endcase
    mul_b = mul_a;
  end

  assign div_start  = cmd.start && (cmd.step inside {ST_PCT, ST_ML, ST_EL, ST_MR, ST_ER});
  assign mul_start  = cmd.start && (cmd.step inside {ST_PSQ, ST_MLSQ, ST_MRSQ});
  assign sqrt_start = cmd.start && (cmd.step inside {ST_LSQRT, ST_RSQRT});
  assign busy       = div_busy | mul_busy | sqrt_busy;

  plrm_div #(.DW(DW)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(dvd), .divisor(dvs),
    .busy(div_busy), .quot(div_q)
  );

  plrm_sqrt u_sqrt (
    .clk, .rst_n, .start(sqrt_start), .radicand(var_r),
    .busy(sqrt_busy), .root(sqrt_q)
  );

  // shift-add multiplier, one operand bit a cycle
  logic [127:0] ma_r, acc_r;
  logic [63:0]  mb_r;
  logic [6:0]   mcnt_r;

  assign mul_busy = mcnt_r != '0;
  assign mul_p    = (|acc_r[127:64]) ? '1 : acc_r[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= '0;
    end else if (mul_start) begin
      ma_r   <= {64'd0, mul_a};
      mb_r   <= mul_b;
      acc_r  <= '0;
      mcnt_r <= 7'd64;
    end else if (mul_busy) begin
      if (mb_r[0]) acc_r <= acc_r + ma_r;
      ma_r   <= ma_r << 1;
      mb_r   <= mb_r >> 1;
      mcnt_r <= mcnt_r - 7'd1;
    end
  end

  // packet path
  logic [31:0] gap, loss;
  logic [32:0] lsec_s, ltot_s;
  logic        dup;

  assign dup    = 32'(in_data.packet_id) == prev_id_r;
  assign gap    = 32'(in_data.content) - latest_r;
  assign loss   = (!first_r && gap > 32'd1 && !gap[31]) ? gap - 32'd1 : '0;
  assign lsec_s = {1'b0, sec_lost_r} + {1'b0, loss};
  assign ltot_s = {1'b0, lost_tot_r} + {1'b0, loss};

  logic [47:0] rr;
  assign rr = 48'(sec_recv_r) * 48'(sec_recv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_id_r  <= '1;
      first_r    <= 1'b1;
      start_r    <= '0;
      latest_r   <= '0;
      lost_tot_r <= '0;
      sec_recv_r <= '0;
      sec_lost_r <= '0;
      tick_cnt_r <= '0;
      lp_sum_r   <= '0;
      lp_sq_r    <= '0;
      r_sum_r    <= '0;
      r_sq_r     <= '0;
    end else begin
      if (cmd.pkt_we && !dup) begin
        if (first_r) start_r <= 32'(in_data.content);
        first_r    <= 1'b0;
        latest_r   <= 32'(in_data.content);
        prev_id_r  <= 32'(in_data.packet_id);
        if (sec_recv_r != '1) sec_recv_r <= sec_recv_r + 24'd1;
        sec_lost_r <= lsec_s[32] ? '1 : lsec_s[31:0];
        lost_tot_r <= ltot_s[32] ? '1 : ltot_s[31:0];
      end
      if (cmd.accum && tick_cnt_r != '1) begin
        tick_cnt_r <= tick_cnt_r + 32'd1;
        lp_sum_r   <= sadd56(lp_sum_r, pct_r);
        lp_sq_r    <= sadd64(lp_sq_r, psq_r);
        r_sum_r    <= sadd56(r_sum_r, 64'(sec_recv_r));
        r_sq_r     <= sadd64(r_sq_r, 64'(rr));
      end
      if (cmd.out_load) begin
        sec_recv_r <= '0;
        sec_lost_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      case (cmd.step)
        ST_PCT:   pct_r <= (den_pct == '0) ? '0 : div_q;
        ST_PSQ:   psq_r <= mul_p;
        ST_ML:    ml_r  <= div_q;
        ST_MR:    mr_r  <= div_q;
        ST_EL:    ex_r  <= div_q;
        ST_ER:    ex_r  <= div_q;
        ST_MLSQ:  var_r <= (ex_r > mul_p) ? ex_r - mul_p : '0;
        ST_MRSQ:  var_r <= (ex_r > mul_p) ? ex_r - mul_p : '0;
        ST_LSQRT: sdl_r <= sqrt_q;
        ST_RSQRT: sdr_r <= sqrt_q;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.data_amount        <= signed'(latest_r - start_r);
      out_r.lost_since_reset   <= lost_tot_r;
      out_r.recv_this_second   <= sec_recv_r;
      out_r.lost_this_second   <= sec_lost_r;
      out_r.loss_percent       <= (|pct_r[63:PCT_W]) ? '1 : pct_r[PCT_W-1:0];
      out_r.mean_loss_percent  <= (|ml_r[63:PCT_W])  ? '1 : ml_r[PCT_W-1:0];
      out_r.stdev_loss_percent <= (|sdl_r[63:PCT_W]) ? '1 : sdl_r[PCT_W-1:0];
      out_r.mean_recv_rate     <= (|mr_r[63:32])     ? '1 : mr_r[31:0];
      out_r.sdev_recv_rate     <= (|sdr_r[63:32])    ? '1 : sdr_r[31:0];
    end
  end

  assign out_data = out_r;
endmodule

@@ hw/rtl/plrm_ctrl.sv @@
module plrm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                busy,
  output plrm_pkg::plrm_cmd_t cmd
);
  import plrm_pkg::*;

  plrm_state_t state_r, state_nxt, after;
  logic        issued_r, issued_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    case (state_r)
      ST_PCT:   after = ST_PSQ;
      ST_PSQ:   after = ST_ACC;
      ST_ML:    after = ST_EL;
      ST_EL:    after = ST_MLSQ;
      ST_MLSQ:  after = ST_LSQRT;
      ST_LSQRT: after = ST_MR;
      ST_MR:    after = ST_ER;
      ST_ER:    after = ST_MRSQ;
      ST_MRSQ:  after = ST_RSQRT;
      default:  after = ST_OUT;
    endcase
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    issued_nxt   = issued_r;
    cmd          = '0;
    cmd.step     = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode) state_nxt = ST_PCT;
          else         cmd.pkt_we = 1'b1;
        end
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = ST_ML;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        // launch the unit, then wait for it to drain
        if (!issued_r) begin
          cmd.start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (!busy) begin
          cmd.capture = 1'b1;
          issued_nxt  = 1'b0;
          state_nxt   = after;
        end
      end
    endcase
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result beat not presented after load");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy)
    else $error("unit launched while busy");

  a_tick_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode) |=> state_r == ST_PCT)
    else $error("tick beat not started");
endmodule
